/* src/sbc_pkg.sv */
// Shared types and constants for the static bias calibration core.
package sbc_pkg;

  localparam int AXES            = 3;
  localparam int SAMPLE_W        = 16;
  localparam int MAG_W           = 17;
  localparam int ADJ_W           = MAG_W + 1;
  localparam int G_W             = 15;
  localparam int DEF_MAX_SAMPLES = 1024;
  localparam logic [G_W-1:0] ONE_G_RESET = 15'd4096;

  typedef enum logic [1:0] {
    ST_ACCUM,
    ST_DIV,
    ST_DONE
  } state_t;

  // Per-lane control, shared by all three lanes
  typedef struct packed {
    logic acc_en;
    logic start;
    logic step;
  } lane_ctl_t;

endpackage

/* src/sbc_lane.sv */
// One axis lane: sample accumulator and restoring divider for the mean.
module sbc_lane
  import sbc_pkg::*;
#(
  parameter int SUM_W = 27,
  parameter int CNT_W = 11
) (
  input  logic                       clk,
  input  logic                       rst,
  input  lane_ctl_t                  ctl,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic        [CNT_W-1:0]    divisor,
  output logic        [MAG_W-1:0]    quo_mag,
  output logic                       quo_neg
);

  logic signed [SUM_W-1:0] acc;
  logic signed [SUM_W-1:0] acc_sum;
  logic        [SUM_W-1:0] dividend;
  logic        [CNT_W-1:0] rem;
  logic        [SUM_W-1:0] quo;
  logic        [CNT_W:0]   trial;
  logic                    fits;

  assign acc_sum  = acc + (ctl.acc_en ? SUM_W'(sample) : '0);
  assign dividend = acc_sum[SUM_W-1] ? SUM_W'(-acc_sum) : SUM_W'(acc_sum);
  assign trial    = {rem, quo[SUM_W-1]};
  assign fits     = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctl.start) begin
      acc <= '0;
    end else if (ctl.acc_en) begin
      acc <= acc_sum;
    end
  end

  // Load magnitude on start, then one quotient bit per step
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      rem     <= '0;
      quo     <= dividend;
      quo_neg <= acc_sum[SUM_W-1];
    end else if (ctl.step) begin
      rem <= fits ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
      quo <= {quo[SUM_W-2:0], fits};
    end
  end

  // Mean magnitude never exceeds one sample's range
  assign quo_mag = quo[MAG_W-1:0];

endmodule

/* src/sbc_merge.sv */
// Merge stage: dominant axis, gravity removal, saturation and output register.
module sbc_merge
  import sbc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic [AXES-1:0][MAG_W-1:0] mag,
  input  logic [AXES-1:0]            neg,
  input  logic                       empty,
  input  logic [G_W-1:0]             one_g,
  input  logic                       load,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [AXES*SAMPLE_W-1:0]   m_tdata,
  output logic                       m_tuser
);

  logic [AXES-1:0]                          dom;
  logic signed [AXES-1:0][ADJ_W-1:0]        adj;
  logic        [AXES-1:0][SAMPLE_W-1:0]     sat;

  assign dom[0] = (mag[0] > mag[1]) && (mag[0] > mag[2]);
  assign dom[1] = (mag[1] > mag[0]) && (mag[1] > mag[2]);
  assign dom[2] = (mag[2] > mag[0]) && (mag[2] > mag[1]);

  always_comb begin
    logic signed [ADJ_W-1:0] mean;
    logic signed [ADJ_W-1:0] g;
    for (int i = 0; i < AXES; i++) begin
      mean = $signed({1'b0, mag[i]});
      if (neg[i]) mean = -mean;
      g = $signed(ADJ_W'(one_g));
      if (!dom[i])      adj[i] = mean;
      else if (neg[i])  adj[i] = mean + g;
      else              adj[i] = mean - g;
      if (empty)
        sat[i] = '0;
      else if ($signed(adj[i]) > $signed(ADJ_W'(32767)))
        sat[i] = 16'h7fff;
      else if ($signed(adj[i]) < -$signed(ADJ_W'(32768)))
        sat[i] = 16'h8000;
      else
        sat[i] = adj[i][SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= sat;
      m_tuser <= empty;
    end
  end

endmodule

/* src/accel_static_bias_calibration_core.sv */
// Top level of the static accelerometer bias calibration core.
//
//  channel  dir  handshake           payload (low bit up)
//  s_*      in   s_tvalid/s_tready   tdata: sample_x, sample_y, sample_z; tuser: sample_good;
//                                    tlast: run_end
//  m_*      out  m_tvalid/m_tready   tdata: offset_x, offset_y, offset_z; tuser: no_samples
//  cfg_*    in   cfg_wen             wdata: one_g_counts
//
//  Samples are taken one per cycle while a run accumulates in the three lanes.
//  The transaction with tlast starts the lane dividers, one quotient bit per step
//  with s_tready low, and then the output register is loaded once it is free.
//  A result waiting on m_tready keeps s_tready low only once the following run
//  has finished dividing too.
//  Reset is synchronous and clears the sums, counters and one_g_counts to 4096.
module accel_static_bias_calibration_core
  import sbc_pkg::*;
#(
  parameter int MAX_SAMPLES = DEF_MAX_SAMPLES
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [AXES*SAMPLE_W-1:0] s_tdata,   // sample_x, sample_y, sample_z
  input  logic                     s_tuser,   // sample_good
  input  logic                     s_tlast,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [AXES*SAMPLE_W-1:0] m_tdata,   // offset_x, offset_y, offset_z
  output logic                     m_tuser,   // no_samples
  input  logic                     cfg_wen,
  input  logic [G_W-1:0]           cfg_wdata
);

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int SUM_W  = SAMPLE_W + CNT_W;
  localparam int STEP_W = $clog2(SUM_W);

  state_t                      state, state_next;
  lane_ctl_t                   ctl;
  logic [G_W-1:0]              one_g;
  logic [CNT_W-1:0]            items_seen;
  logic [CNT_W-1:0]            good_count;
  logic [CNT_W-1:0]            good_final;
  logic [CNT_W-1:0]            div_cnt;
  logic [STEP_W-1:0]           step;
  logic                        empty;
  logic                        s_accept;
  logic                        counted;
  logic                        load;
  logic [AXES-1:0][MAG_W-1:0]  mag;
  logic [AXES-1:0]             neg;

  assign s_accept   = s_tvalid && s_tready;
  assign counted    = (items_seen < CNT_W'(MAX_SAMPLES)) && s_tuser;
  assign good_final = good_count + CNT_W'(counted);

  always_ff @(posedge clk) begin
    if (rst) begin
      one_g <= ONE_G_RESET;
    end else if (cfg_wen) begin
      one_g <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    load       = 1'b0;
    ctl        = '0;
    unique case (state)
      ST_ACCUM: begin
        s_tready   = 1'b1;
        ctl.acc_en = s_tvalid && counted;
        ctl.start  = s_tvalid && s_tlast;
        if (s_tvalid && s_tlast) state_next = ST_DIV;
      end
      ST_DIV: begin
        ctl.step = 1'b1;
        if (step == '0) state_next = ST_DONE;
      end
      ST_DONE: begin
        // hold until the output register is free
        if (!m_tvalid || m_tready) begin
          load       = 1'b1;
          state_next = ST_ACCUM;
        end
      end
      default: state_next = ST_ACCUM;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      items_seen <= '0;
      good_count <= '0;
    end else if (ctl.start) begin
      items_seen <= '0;
      good_count <= '0;
    end else if (s_accept && items_seen < CNT_W'(MAX_SAMPLES)) begin
      items_seen <= items_seen + 1'b1;
      good_count <= good_final;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      div_cnt <= good_final;
      empty   <= (good_final == '0);
      step    <= STEP_W'(SUM_W - 1);
    end else if (ctl.step) begin
      step <= step - 1'b1;
    end
  end

  for (genvar a = 0; a < AXES; a++) begin : g_lane
    sbc_lane #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
    ) u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .sample  ($signed(s_tdata[a*SAMPLE_W +: SAMPLE_W])),
      .divisor (div_cnt),
      .quo_mag (mag[a]),
      .quo_neg (neg[a])
    );
  end

  sbc_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .mag      (mag),
    .neg      (neg),
    .empty    (empty),
    .one_g    (one_g),
    .load     (load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  a_run_end_divides: assert property (@(posedge clk) disable iff (rst)
    s_accept && s_tlast |=> state == ST_DIV)
    else $error("run end did not start the dividers");

  a_div_length: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV && step == '0 |=> state == ST_DONE)
    else $error("division did not finish on the last step");

  a_capacity: assert property (@(posedge clk) disable iff (rst)
    items_seen <= CNT_W'(MAX_SAMPLES) && good_count <= items_seen)
    else $error("sample counters beyond capacity");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_DONE)
    else $error("result raised outside the done state");

endmodule
